// ===== sv/ucc_pkg.sv =====
// shared types, constants and the byte classifier for the utf-8 codepoint counter
// no dependencies
package ucc_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;

   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] LEAD_SURR = 8'hED;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_LO   = 8'h80;
   localparam logic [7:0] CONT_HI   = 8'hBF;
   localparam logic [7:0] SEC_E0_LO = 8'hA0;
   localparam logic [7:0] SEC_ED_HI = 8'h9F;
   localparam logic [7:0] SEC_F0_LO = 8'h90;
   localparam logic [7:0] SEC_F4_HI = 8'h8F;

   // which second-byte range a lead imposes
   typedef enum logic [2:0] {
      LEAD_PLAIN = 3'd0,
      LEAD_E0    = 3'd1,
      LEAD_ED    = 3'd2,
      LEAD_F0    = 3'd3,
      LEAD_F4    = 3'd4
   } lead_kind_type;

   // one classified byte as it travels from front to back
   typedef struct packed {
      logic          last;
      logic [1:0]    need;
      lead_kind_type kind;
      logic          cont;
      logic          r_a0_bf;
      logic          r_80_9f;
      logic          r_90_bf;
      logic          r_80_8f;
   } ucc_item_type;

   function automatic ucc_item_type ucc_classify(input logic [7:0] b, input logic last);
      ucc_item_type it;
      it.last    = last;
      it.cont    = (b & CONT_MASK) == CONT_LO;
      it.r_a0_bf = (b >= SEC_E0_LO) && (b <= CONT_HI);
      it.r_80_9f = (b >= CONT_LO) && (b <= SEC_ED_HI);
      it.r_90_bf = (b >= SEC_F0_LO) && (b <= CONT_HI);
      it.r_80_8f = (b >= CONT_LO) && (b <= SEC_F4_HI);
      if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
         it.need = 2'd1;
      end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
         it.need = 2'd2;
      end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
         it.need = 2'd3;
      end else begin
         it.need = 2'd0;
      end
      case (b)
         LEAD3_LO:  it.kind = LEAD_E0;
         LEAD_SURR: it.kind = LEAD_ED;
         LEAD4_LO:  it.kind = LEAD_F0;
         LEAD4_HI:  it.kind = LEAD_F4;
         default:   it.kind = LEAD_PLAIN;
      endcase
      return it;
   endfunction

endpackage

// ===== sv/ucc_front.sv =====
// front part: accepts bytes, classifies them and queues them for the back part
// depends on ucc_pkg
module ucc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_string,
   output logic                item_valid,
   output ucc_pkg::ucc_item_type item,
   input  logic                item_take
);
   import ucc_pkg::*;

   ucc_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         wr_en, rd_en;

   assign full       = cnt_ff == 2'd2;
   assign item_valid = cnt_ff != 2'd0;
   assign item       = q_ff[rd_ptr_ff];
   assign wr_en      = push && !full;
   assign rd_en      = item_take && item_valid;

   always_comb begin
      wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload slots, classified on the way in
   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= ucc_classify(req_data_byte, req_end_of_string);
      end
   end

endmodule

// ===== sv/ucc_back.sv =====
// back part: sequence tracking, saturating count and result generation
// depends on ucc_pkg
module ucc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  ucc_pkg::ucc_item_type         item,
   output logic                          item_take,
   input  logic                          res_room,
   output logic                          res_valid,
   output logic [ucc_pkg::COUNT_WIDTH-1:0] res_count
);
   import ucc_pkg::*;

   logic [1:0]             held_ff, held_in;
   logic [1:0]             exp_ff, exp_in;
   lead_kind_type          kind_ff, kind_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] total;
   logic [COUNT_WIDTH:0]   sum;
   logic [2:0]             add_k;
   logic [2:0]             next_held;
   logic                   fits;
   logic                   reopen;

   // only a last byte needs room for its result
   assign item_take = item_valid && (!item.last || res_room);
   assign res_valid = item_take && item.last;
   assign res_count = total;

   always_comb begin
      held_in   = held_ff;
      exp_in    = exp_ff;
      kind_in   = kind_ff;
      add_k     = 3'd0;
      fits      = 1'b0;
      reopen    = 1'b0;
      next_held = {1'b0, held_ff} + 3'd1;
      if (held_ff == 2'd0) begin
         reopen = 1'b1;
      end else begin
         if (held_ff == 2'd1) begin
            case (kind_ff)
               LEAD_E0: fits = item.r_a0_bf;
               LEAD_ED: fits = item.r_80_9f;
               LEAD_F0: fits = item.r_90_bf;
               LEAD_F4: fits = item.r_80_8f;
               default: fits = item.cont;
            endcase
         end else begin
            fits = item.cont;
         end
         if (fits) begin
            if (next_held > {1'b0, exp_ff}) begin
               // sequence complete
               add_k   = 3'd1;
               held_in = 2'd0;
               exp_in  = 2'd0;
            end else begin
               held_in = next_held[1:0];
            end
         end else begin
            // broken sequence: held bytes count singly, byte is re-examined
            add_k  = {1'b0, held_ff};
            reopen = 1'b1;
         end
      end
      if (reopen) begin
         held_in = 2'd0;
         exp_in  = 2'd0;
         kind_in = LEAD_PLAIN;
         if (item.need == 2'd0) begin
            add_k = add_k + 3'd1;
         end else begin
            held_in = 2'd1;
            exp_in  = item.need;
            kind_in = item.kind;
         end
      end
      if (item.last) begin
         // truncated tail counts byte by byte
         add_k   = add_k + {1'b0, held_in};
         held_in = 2'd0;
         exp_in  = 2'd0;
      end
      sum      = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(add_k);
      total    = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
      count_in = item.last ? {COUNT_WIDTH{1'b0}} : total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 2'd0;
         exp_ff   <= 2'd0;
         kind_ff  <= LEAD_PLAIN;
         count_ff <= '0;
      end else if (item_take) begin
         held_ff  <= held_in;
         exp_ff   <= exp_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/utf8_codepoint_counter_unit.sv =====
// top level of the utf-8 codepoint counter: front/back parts and the result queue
// depends on ucc_pkg, ucc_front, ucc_back
//
//   channel   handshake     payload
//   request   push / full   req_data_byte[7:0], req_end_of_string
//   response  empty / pop   rsp_codepoint_count[31:0]
//
// one byte per cycle sustained while the result queue has room; a byte passes the two-entry
// front queue and is consumed by the back part, which updates the sequence state.
// a result is written into the two-entry result queue at the edge that consumes
// its last byte, so empty drops once that byte has left the front queue.
// reset (synchronous) empties both queues and clears the sequence state and count.
// a full result queue holds a last byte at the head of the front queue; bytes
// behind it wait, and full rises once the front queue holds two bytes.
module utf8_codepoint_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_codepoint_count
);
   import ucc_pkg::*;

   ucc_item_type           item;
   logic                   item_valid;
   logic                   item_take;
   logic                   res_valid;
   logic [COUNT_WIDTH-1:0] res_count;
   logic                   res_room;

   // result queue
   logic [OUT_WIDTH-1:0]   rq_ff [2];
   logic                   rq_wr_ff, rq_wr_in;
   logic                   rq_rd_ff, rq_rd_in;
   logic [1:0]             rq_cnt_ff, rq_cnt_in;
   logic                   rq_pop;

   ucc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take)
   );

   ucc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .res_room   (res_room),
      .res_valid  (res_valid),
      .res_count  (res_count)
   );

   assign res_room            = rq_cnt_ff != 2'd2;
   assign empty               = rq_cnt_ff == 2'd0;
   assign rq_pop              = pop && !empty;
   assign rsp_codepoint_count = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in  = res_valid ? !rq_wr_ff : rq_wr_ff;
      rq_rd_in  = rq_pop ? !rq_rd_ff : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (res_valid && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 2'd1;
      end else if (!res_valid && rq_pop) begin
         rq_cnt_in = rq_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   // count is carried at its own width, beat holds the low output bits
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rq_ff[rq_wr_ff] <= OUT_WIDTH'(res_count);
      end
   end

endmodule

// ===== dv/utf8_codepoint_counter_unit_tb.sv =====
// self-checking testbench for utf8_codepoint_counter_unit: byte strings in, codepoint counts out
// predicts each count from its own model of the strict utf-8 table and compares in order
// depends on ucc_pkg and utf8_codepoint_counter_unit
module utf8_codepoint_counter_unit_tb;
   import ucc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_BYTES  = 460;
   localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } string_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_codepoint_count;

   // stimulus queue and the counts still owed by the block
   string_beat_type pending_beats[$];
   logic [31:0]     counts_due[$];
   int              bytes_queued = 0;

   // knobs written by the sequencer, read by the driver and the receiver
   int phase_num     = 1;
   int send_idle_pct = 6;
   int recv_idle_pct = 63;

   logic beat_in_taken = 1'b0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   // predictor state: the open sequence and the running tally
   logic [7:0]             open_lead = '0;
   logic [1:0]             open_held = '0;
   logic [1:0]             open_need = '0;
   logic [COUNT_WIDTH-1:0] cp_tally = '0;

   utf8_codepoint_counter_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_data_byte       (req_data_byte),
      .req_end_of_string   (req_end_of_string),
      .empty               (empty),
      .pop                 (pop),
      .rsp_codepoint_count (rsp_codepoint_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // saturating add, k is at most three
   function automatic logic [COUNT_WIDTH-1:0] tally_plus(input logic [COUNT_WIDTH-1:0] a,
                                                         input int unsigned k);
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, a} + k;
      if (sum > {1'b0, TALLY_MAX}) begin
         return TALLY_MAX;
      end
      return sum[COUNT_WIDTH-1:0];
   endfunction

   task automatic drop_open();
      open_lead = '0;
      open_held = '0;
      open_need = '0;
   endtask

   // look at a byte as a possible lead; anything that cannot lead counts alone
   task automatic open_or_count(input logic [7:0] b);
      logic [1:0] need;
      drop_open();
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         need = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         need = 2'd2;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         need = 2'd3;
      end else begin
         need = 2'd0;
      end
      if (need == 2'd0) begin
         cp_tally = tally_plus(cp_tally, 1);
      end else begin
         open_lead = b;
         open_held = 2'd1;
         open_need = need;
      end
   endtask

   // one accepted byte; a flagged byte flushes and owes one count
   task automatic predict_count_beat(input logic [7:0] b, input logic last);
      logic fits;
      if (open_held == 2'd0 || open_need == 2'd0) begin
         open_or_count(b);
      end else begin
         if (open_held == 2'd1) begin
            // second byte range narrowed after some leads
            case (open_lead)
               LEAD3_LO:  fits = b >= SEC_E0_LO && b <= CONT_HI;
               LEAD_SURR: fits = b >= CONT_LO && b <= SEC_ED_HI;
               LEAD4_LO:  fits = b >= SEC_F0_LO && b <= CONT_HI;
               LEAD4_HI:  fits = b >= CONT_LO && b <= SEC_F4_HI;
               default:   fits = (b & CONT_MASK) == CONT_LO;
            endcase
         end else begin
            fits = (b & CONT_MASK) == CONT_LO;
         end
         if (fits) begin
            open_held = open_held + 2'd1;
            // held count wraps to zero on the fourth byte of a four-byte sequence
            if (open_held == 2'd0 || open_held > open_need) begin
               cp_tally = tally_plus(cp_tally, 1);
               drop_open();
            end
         end else begin
            // broken sequence: held bytes count singly, breaking byte starts over
            cp_tally = tally_plus(cp_tally, 32'(open_held));
            open_or_count(b);
         end
      end
      if (last) begin
         cp_tally = tally_plus(cp_tally, 32'(open_held));
         counts_due.push_back(32'(cp_tally));
         drop_open();
         cp_tally = '0;
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus generation
   // ---------------------------------------------------------------

   task automatic push_string(input logic [7:0] s[$]);
      string_beat_type beat;
      foreach (s[i]) begin
         beat.data = s[i];
         beat.last = (i == s.size() - 1);
         pending_beats.push_back(beat);
         bytes_queued++;
      end
   endtask

   // directed string given as hex, first byte in the top of the used bits
   task automatic push_hex_string(input logic [127:0] bytes, input int n);
      logic [7:0] s[$];
      for (int i = 0; i < n; i++) begin
         s.push_back(bytes[8*(n-1-i) +: 8]);
      end
      push_string(s);
   endtask

   // mostly well-formed sequences, the rest truncated, broken, edge bytes and noise
   task automatic push_random_string(input int max_units);
      logic [7:0] s[$];
      int         units;
      int         pick;
      int         conts;
      int         keep;
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      units = $urandom_range(1, max_units);
      for (int u = 0; u < units; u++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            s.push_back(8'($urandom_range(0, 127)));
         end else if (pick < 88) begin
            conts = $urandom_range(1, 3);
            case (conts)
               1: lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
               2: begin
                  if ($urandom_range(0, 1) == 0) begin
                     lead = ($urandom_range(0, 1) == 0) ? LEAD3_LO : LEAD_SURR;
                  end else begin
                     lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                  end
               end
               default: begin
                  if ($urandom_range(0, 1) == 0) begin
                     lead = ($urandom_range(0, 1) == 0) ? LEAD4_LO : LEAD4_HI;
                  end else begin
                     lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                  end
               end
            endcase
            lo = CONT_LO;
            hi = CONT_HI;
            case (lead)
               LEAD3_LO:  lo = SEC_E0_LO;
               LEAD_SURR: hi = SEC_ED_HI;
               LEAD4_LO:  lo = SEC_F0_LO;
               LEAD4_HI:  hi = SEC_F4_HI;
               default:   ;
            endcase
            // truncated sequences keep only part of their continuation bytes
            keep = (pick < 70) ? conts : $urandom_range(0, conts - 1);
            s.push_back(lead);
            for (int i = 0; i < keep; i++) begin
               if (i == 0) begin
                  s.push_back(8'($urandom_range(lo, hi)));
               end else begin
                  s.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
               end
            end
            // some truncated sequences get an arbitrary byte right after
            if (pick >= 80) begin
               s.push_back(8'($urandom));
            end
         end else if (pick < 94) begin
            case ($urandom_range(0, 6))
               0: s.push_back(8'($urandom_range(CONT_MASK, LEAD2_LO - 1)));
               1: s.push_back(8'($urandom_range(LEAD4_HI + 1, 8'hFF)));
               2: s.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
               3: begin
                  s.push_back(LEAD3_LO);
                  s.push_back(8'($urandom_range(CONT_LO, SEC_ED_HI)));
               end
               4: begin
                  s.push_back(LEAD_SURR);
                  s.push_back(8'($urandom_range(SEC_E0_LO, CONT_HI)));
               end
               5: begin
                  s.push_back(LEAD4_LO);
                  s.push_back(8'($urandom_range(CONT_LO, SEC_F4_HI)));
               end
               default: begin
                  s.push_back(LEAD4_HI);
                  s.push_back(8'($urandom_range(SEC_F0_LO, CONT_HI)));
               end
            endcase
         end else begin
            s.push_back(8'($urandom));
         end
      end
      push_string(s);
   endtask

   task automatic push_phase_strings(input int target);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < target) begin
         // now and then a long string so counts get past a few dozen
         push_random_string(($urandom_range(0, 19) == 0) ? 40 : 6);
      end
   endtask

   // ---------------------------------------------------------------
   // driver: request side changes on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      string_beat_type beat;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || beat_in_taken) begin
         // the previous beat went through, or nothing was on offer
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            beat = pending_beats.pop_front();
            req_data_byte     <= beat.data;
            req_end_of_string <= beat.last;
            push              <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: pop changes on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         pop <= 1'b0;
      end else begin
         // long hold at the start of the last phase so the result queue fills
         // and last bytes back up into the input
         if (phase_num == 3 && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: both handshakes sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      logic [31:0] want;
      if (reset) begin
         beat_in_taken <= 1'b0;
      end else begin
         beat_in_taken <= push && !full;
         if (push && !full) begin
            predict_count_beat(req_data_byte, req_end_of_string);
         end
         if (pop && !empty) begin
            if (counts_due.size() == 0) begin
               $display("%0t: unexpected count beat, expected none actual %0d", $time,
                        rsp_codepoint_count);
               mismatch_count++;
            end else begin
               want = counts_due.pop_front();
               if (rsp_codepoint_count !== want) begin
                  $display("%0t: codepoint_count mismatch, expected %0d actual %0d",
                           $time, want, rsp_codepoint_count);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("utf8_codepoint_counter_unit_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // sequencer: reset, directed strings, then three idling phases
   // ---------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single nul byte
      push_hex_string(128'h00, 1);
      // ascii, largest two-byte, smallest three-byte after e0, largest f4 sequence,
      // stray continuation, ff as last byte
      push_hex_string(128'h7F_DF_BF_E0_A0_80_F4_8F_BF_BF_80_FF, 12);
      // surrogate, beyond the top codepoint, overlong after e0, bad leads,
      // sequence truncated by the end of string
      push_hex_string(128'hED_A0_F4_90_E0_9F_C1_F5_E1_80, 10);

      // sender rarely idles, receiver mostly stalls
      push_phase_strings(PHASE_BYTES);
      while (pending_beats.size() != 0) @(posedge clock);

      // sender mostly idles, receiver rarely stalls
      send_idle_pct = 63;
      recv_idle_pct = 6;
      phase_num     = 2;
      push_phase_strings(PHASE_BYTES);
      while (pending_beats.size() != 0) @(posedge clock);

      // no idling, apart from the long hold in the receiver
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_phase_strings(PHASE_BYTES);
      phase_num     = 3;
      while (pending_beats.size() != 0 || push) @(posedge clock);

      while (counts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("utf8_codepoint_counter_unit_tb: done, clean");
      end else begin
         $display("utf8_codepoint_counter_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ucc_pkg.sv
sv/ucc_front.sv
sv/ucc_back.sv
sv/utf8_codepoint_counter_unit.sv
dv/utf8_codepoint_counter_unit_tb.sv
